// ----- src/expiring_action_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Expiring action queue assertion macros
// Shared concurrent assertion forms for the expiring action queue.
// ----------------------------------------------------------------------------
`ifndef EXPIRING_ACTION_QUEUE_MACROS_SVH
`define EXPIRING_ACTION_QUEUE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define EAQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define EAQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/eaq_pkg.sv -----
// ----------------------------------------------------------------------------
// Expiring action queue package
// Field widths and request codes shared by the channels and the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eaq_pkg;

  // Payload field widths
  localparam int REQ_TYPE_W  = 3;
  localparam int CODE_W      = 4;
  localparam int OCC_W       = 4;
  localparam int TOTAL_W     = 32;
  localparam int LIFE_CFG_W  = 8;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_PUSH       = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CONSUME    = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_TICK       = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR      = 3'd3;
  localparam logic [REQ_TYPE_W-1:0] REQ_RST_COUNTS = 3'd4;

  // Lifetime register reset value
  localparam logic [LIFE_CFG_W-1:0] LIFE_RESET = 8'd8;

endpackage

// ----- src/eaq_ifs.sv -----
// ----------------------------------------------------------------------------
// Expiring action queue channels
// Valid/ready channels for requests, results and the lifetime register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eaq_req_if;
  import eaq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [CODE_W-1:0]     action_code;
  logic                  paused;

  modport source (output valid, req_type, action_code, paused, input ready);
  modport sink   (input valid, req_type, action_code, paused, output ready);
endinterface

interface eaq_rsp_if;
  import eaq_pkg::*;

  logic               valid;
  logic               ready;
  logic               success;
  logic [OCC_W-1:0]   occupancy;
  logic [TOTAL_W-1:0] expired_total;
  logic [TOTAL_W-1:0] overflow_total;

  modport source (output valid, success, occupancy, expired_total, overflow_total,
                  input ready);
  modport sink   (input valid, success, occupancy, expired_total, overflow_total,
                  output ready);
endinterface

interface eaq_cfg_if;
  import eaq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LIFE_CFG_W-1:0] lifetime_ticks;

  modport source (output valid, lifetime_ticks, input ready);
  modport sink   (input valid, lifetime_ticks, output ready);
endinterface

// ----- src/expiring_action_queue.sv -----
// Sequence: push, clear, reset-counters, paused tick and unknown requests pass from the
//   request beat through the execute and done states into the result register; consume
//   and unpaused tick walk the queue first, one entry memory read per held entry.
// Throughput: one request at a time; the next request beat is taken once the
//   result sits in the output register. Lifetime writes are taken at any time.
// Reset (rst, synchronous): queue empty, both counters zero, lifetime 8.
// ----------------------------------------------------------------------------
// Expiring action queue
// Ordered buffer of action codes with per-entry lifetimes, held in one memory
// and compacted by a read-modify-write walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expiring_action_queue #(
  parameter int CAPACITY      = 8,
  parameter int ACTION_BITS   = 4,
  parameter int LIFETIME_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  eaq_req_if.sink    req,
  eaq_rsp_if.source  rsp,
  eaq_cfg_if.sink    cfg
);
  import eaq_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = ACTION_BITS + LIFETIME_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]               state, state_next;
  logic [CNT_W-1:0]         fill, fill_next;
  logic [CNT_W-1:0]         rd_cnt, rd_cnt_next;
  logic [CNT_W-1:0]         wr_cnt, wr_cnt_next;
  logic                     pend, pend_next;
  logic                     found, found_next;
  logic                     ok, ok_next;
  logic [TOTAL_W-1:0]       exp_cnt, exp_cnt_next;
  logic [TOTAL_W-1:0]       ovf_cnt, ovf_cnt_next;
  logic [LIFE_CFG_W-1:0]    life_reg;
  logic [REQ_TYPE_W-1:0]    op;
  logic [ACTION_BITS-1:0]   code_q;
  logic                     paused_q;

  logic                     rsp_valid;
  logic                     rsp_success;
  logic [OCC_W-1:0]         rsp_occ;
  logic [TOTAL_W-1:0]       rsp_exp;
  logic [TOTAL_W-1:0]       rsp_ovf;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ENT_W-1:0]         mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [ENT_W-1:0]         mem_q;

  logic [15:0]              code_wide;
  logic [15:0]              life_wide;
  logic [ACTION_BITS-1:0]   q_act;
  logic [LIFETIME_BITS-1:0] q_left;
  logic                     drop;
  logic                     req_beat;
  logic                     rsp_load;

  // Fit the payload code and the lifetime register to the stored widths
  assign code_wide = 16'(req.action_code);
  assign life_wide = 16'(life_reg);
  assign q_act     = mem_q[ENT_W-1:LIFETIME_BITS];
  assign q_left    = mem_q[LIFETIME_BITS-1:0] - 1'b1;

  assign req.ready = (state == S_IDLE);
  assign req_beat  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  assign rsp.valid          = rsp_valid;
  assign rsp.success        = rsp_success;
  assign rsp.occupancy      = rsp_occ;
  assign rsp.expired_total  = rsp_exp;
  assign rsp.overflow_total = rsp_ovf;

  eaq_entry_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // Sequence requests and walk the entries
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    rd_cnt_next  = rd_cnt;
    wr_cnt_next  = wr_cnt;
    pend_next    = pend;
    found_next   = found;
    ok_next      = ok;
    exp_cnt_next = exp_cnt;
    ovf_cnt_next = ovf_cnt;
    mem_we       = 1'b0;
    mem_waddr    = fill[AW-1:0];
    mem_wdata    = {code_q, life_wide[LIFETIME_BITS-1:0]};
    mem_re       = 1'b0;
    mem_raddr    = rd_cnt[AW-1:0];
    drop         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_beat) begin
          ok_next     = 1'b0;
          found_next  = 1'b0;
          rd_cnt_next = '0;
          wr_cnt_next = '0;
          pend_next   = 1'b0;
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        unique case (op)
          REQ_PUSH: begin
            if (fill == CNT_W'(CAPACITY)) begin
              ovf_cnt_next = ovf_cnt + 1'b1;
            end else begin
              mem_we    = 1'b1;
              fill_next = fill + 1'b1;
              ok_next   = 1'b1;
            end
          end
          REQ_CONSUME: begin
            state_next = S_WALK;
          end
          REQ_TICK: begin
            if (!paused_q) begin
              state_next = S_WALK;
            end
          end
          REQ_CLEAR: begin
            fill_next = '0;
          end
          REQ_RST_COUNTS: begin
            exp_cnt_next = '0;
            ovf_cnt_next = '0;
          end
          default: begin
          end
        endcase
      end

      S_WALK: begin
        if (!pend && rd_cnt == fill) begin
          // All survivors written back: close the walk
          fill_next  = wr_cnt;
          ok_next    = (op == REQ_CONSUME) && found;
          state_next = S_DONE;
        end else begin
          // Issue the next read
          if (rd_cnt != fill) begin
            mem_re      = 1'b1;
            rd_cnt_next = rd_cnt + 1'b1;
            pend_next   = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
          // Drop or compact the entry that came back
          if (pend) begin
            if (op == REQ_CONSUME) begin
              drop      = !found && (q_act == code_q);
              mem_wdata = mem_q;
              if (drop) begin
                found_next = 1'b1;
              end
            end else begin
              drop      = (q_left == '0);
              mem_wdata = {q_act, q_left};
              if (drop) begin
                exp_cnt_next = exp_cnt + 1'b1;
              end
            end
            if (!drop) begin
              mem_we      = 1'b1;
              mem_waddr   = wr_cnt[AW-1:0];
              wr_cnt_next = wr_cnt + 1'b1;
            end
          end
        end
      end

      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      rd_cnt   <= '0;
      wr_cnt   <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
      ok       <= 1'b0;
      exp_cnt  <= '0;
      ovf_cnt  <= '0;
      life_reg <= LIFE_RESET;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      rd_cnt  <= rd_cnt_next;
      wr_cnt  <= wr_cnt_next;
      pend    <= pend_next;
      found   <= found_next;
      ok      <= ok_next;
      exp_cnt <= exp_cnt_next;
      ovf_cnt <= ovf_cnt_next;
      if (cfg.valid && cfg.ready) begin
        life_reg <= cfg.lifetime_ticks;
      end
    end
  end

  // Hold the request beat
  always_ff @(posedge clk) begin
    if (req_beat) begin
      op       <= req.req_type;
      code_q   <= code_wide[ACTION_BITS-1:0];
      paused_q <= req.paused;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_success <= ok;
      rsp_occ     <= OCC_W'(fill);
      rsp_exp     <= exp_cnt;
      rsp_ovf     <= ovf_cnt;
    end
  end

`include "expiring_action_queue_macros.svh"

  `EAQ_ASSERT_ALWAYS(a_fill_bound, clk, rst, fill <= CNT_W'(CAPACITY), "fill above capacity")
  `EAQ_ASSERT_IMPLY(a_write_behind_read, clk, rst, (state == S_WALK) && pend, wr_cnt < rd_cnt, "compaction write overtook read")
  `EAQ_ASSERT_IMPLY(a_waddr_range, clk, rst, mem_we, int'(mem_waddr) < CAPACITY, "entry write out of range")
  `EAQ_ASSERT_IMPLY(a_ready_idle_only, clk, rst, req.ready, !pend && (state == S_IDLE), "request taken while busy")

endmodule

// ----- src/eaq_entry_ram.sv -----
// ----------------------------------------------------------------------------
// Expiring action queue entry memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eaq_entry_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 12,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/eaq_status_checker.sv -----
// ----------------------------------------------------------------------------
// Expiring action queue status checker
// Watches the request, result and lifetime channels, keeps its own copy of
// the queue, and compares each result beat with the status it predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eaq_status_checker (
  input  logic        clk,
  input  logic        rst,
  eaq_req_if          req,
  eaq_rsp_if          rsp,
  eaq_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned checked
);
  import eaq_pkg::*;

  localparam int DEPTH = 8;
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic               success;
    logic [OCC_W-1:0]   occupancy;
    logic [TOTAL_W-1:0] expired_total;
    logic [TOTAL_W-1:0] overflow_total;
  } queue_status_t;

  // Shadow copy of the queue contents, counters and lifetime register
  logic [CODE_W-1:0]     slot_code [DEPTH];
  logic [LIFE_CFG_W-1:0] slot_life [DEPTH];
  int unsigned           held;
  logic [TOTAL_W-1:0]    expired_cnt;
  logic [TOTAL_W-1:0]    overflow_cnt;
  logic [LIFE_CFG_W-1:0] lifetime;

  queue_status_t awaited_status [$];
  queue_status_t predicted;
  queue_status_t seen;
  int unsigned   err_n;
  int unsigned   checked_n;

  // Apply one request to the shadow queue and return the status it yields
  task automatic apply_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [CODE_W-1:0] code, input logic hold,
                               output queue_status_t st);
    logic                  ok;
    int                    hit;
    int unsigned           wr;
    logic [LIFE_CFG_W-1:0] left;
    ok = 1'b0;
    case (kind)
      REQ_PUSH: begin
        if (held >= DEPTH) begin
          overflow_cnt = overflow_cnt + 1'b1;
        end else begin
          slot_code[held] = code;
          slot_life[held] = lifetime;
          held++;
          ok = 1'b1;
        end
      end
      REQ_CONSUME: begin
        // remove the oldest matching entry and close the gap
        hit = -1;
        for (int i = 0; i < held; i++) begin
          if (hit < 0 && slot_code[i] == code) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit + 1; j < held; j++) begin
            slot_code[j-1] = slot_code[j];
            slot_life[j-1] = slot_life[j];
          end
          held--;
          ok = 1'b1;
        end
      end
      REQ_TICK: begin
        // age every entry unless paused; a lifetime of zero wraps and lives on
        if (!hold) begin
          wr = 0;
          for (int i = 0; i < held; i++) begin
            left = slot_life[i] - 1'b1;
            if (left == '0) begin
              expired_cnt = expired_cnt + 1'b1;
            end else begin
              slot_code[wr] = slot_code[i];
              slot_life[wr] = left;
              wr++;
            end
          end
          held = wr;
        end
      end
      REQ_CLEAR: begin
        held = 0;
      end
      REQ_RST_COUNTS: begin
        expired_cnt  = '0;
        overflow_cnt = '0;
      end
      default: begin
      end
    endcase
    st.success        = ok;
    st.occupancy      = held[OCC_W-1:0];
    st.expired_total  = expired_cnt;
    st.overflow_total = overflow_cnt;
  endtask

  // Track every beat and compare results in order
  always @(posedge clk) begin
    if (rst) begin
      held         = 0;
      expired_cnt  = '0;
      overflow_cnt = '0;
      lifetime     = LIFE_RESET;
      awaited_status.delete();
      err_n        = 0;
      checked_n    = 0;
    end else begin
      if (cfg.valid && cfg.ready) lifetime = cfg.lifetime_ticks;
      if (rsp.valid && rsp.ready) begin
        seen.success        = rsp.success;
        seen.occupancy      = rsp.occupancy;
        seen.expired_total  = rsp.expired_total;
        seen.overflow_total = rsp.overflow_total;
        checked_n++;
        if (awaited_status.size() == 0) begin
          err_n++;
          if (err_n <= REPORT_CAP)
            $display("%0t: result beat with no request waiting", $time);
        end else begin
          predicted = awaited_status.pop_front();
          if (seen !== predicted) begin
            err_n++;
            if (err_n <= REPORT_CAP)
              $display({"%0t: status mismatch, expected success=%0b occ=%0d ",
                        "expired=%0d overflow=%0d, got success=%0b occ=%0d ",
                        "expired=%0d overflow=%0d"}, $time,
                       predicted.success, predicted.occupancy,
                       predicted.expired_total, predicted.overflow_total,
                       seen.success, seen.occupancy, seen.expired_total,
                       seen.overflow_total);
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.action_code, req.paused, predicted);
        awaited_status.push_back(predicted);
      end
    end
    mismatches <= err_n;
    awaited    <= awaited_status.size();
    checked    <= checked_n;
  end

endmodule

// ----- tb/sv/expiring_action_queue_tb.sv -----
// ----------------------------------------------------------------------------
// Expiring action queue testbench
// Drives directed and random requests with random idle gaps on both sides,
// changes the lifetime register between drained phases, and leaves result
// checking to the status checker placed beside the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module expiring_action_queue_tb;
  import eaq_pkg::*;

  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 130;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  // Request codes the queue does not define
  localparam logic [REQ_TYPE_W-1:0] REQ_UNDEF_A = 3'd5;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNDEF_B = 3'd6;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNDEF_C = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  bit          calm;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned kind_seen [8];
  int unsigned settings_used;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned checked;
  int unsigned life_plan [PHASES] = '{1, 3, 2, 0, 255, 5, 0, 4, 6, 128};

  eaq_req_if req_ch ();
  eaq_rsp_if rsp_ch ();
  eaq_cfg_if cfg_ch ();

  expiring_action_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  eaq_status_checker status_watch (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .awaited    (awaited),
    .checked    (checked)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one, none in calm stretches
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      hold_left = idle_gap();
      rsp_ch.ready <= (hold_left == 0);
      if (hold_left > 0) hold_left--;
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one request beat; keep valid high across back-to-back beats
  task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                              input logic [CODE_W-1:0] code, input logic hold);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.action_code <= code;
    req_ch.paused      <= hold;
    do @(posedge clk); while (!req_ch.ready);
    kind_seen[kind]++;
  endtask

  // Drop valid and wait until every result is back and the queue is quiet
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [LIFE_CFG_W-1:0] ticks);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.lifetime_ticks <= ticks;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Push-heavy mix with codes mostly from a narrow set so consumes hit
  task automatic random_request();
    int unsigned           roll;
    logic [REQ_TYPE_W-1:0] kind;
    logic [CODE_W-1:0]     code;
    logic                  hold;
    roll = $urandom_range(0, 99);
    code = ($urandom_range(0, 4) != 0) ? CODE_W'($urandom_range(0, 3))
                                       : CODE_W'($urandom_range(0, 15));
    hold = ($urandom_range(0, 4) == 0);
    if (roll < 36) kind = REQ_PUSH;
    else if (roll < 62) kind = REQ_CONSUME;
    else if (roll < 88) kind = REQ_TICK;
    else if (roll < 92) kind = REQ_CLEAR;
    else if (roll < 95) kind = REQ_RST_COUNTS;
    else begin
      case ($urandom_range(0, 2))
        0: kind = REQ_UNDEF_A;
        1: kind = REQ_UNDEF_B;
        default: kind = REQ_UNDEF_C;
      endcase
    end
    send_request(kind, code, hold);
  endtask

  initial begin
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_PUSH;
    req_ch.action_code    <= '0;
    req_ch.paused         <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.lifetime_ticks <= LIFE_RESET;
    calm          = 1'b1;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue, fill to the limit, overflow, consume, aging
    calm = 1'b0;
    send_request(REQ_TICK, 4'd0, 1'b0);
    send_request(REQ_CONSUME, 4'd0, 1'b0);
    send_request(REQ_PUSH, 4'd0, 1'b0);
    send_request(REQ_PUSH, 4'd15, 1'b1);
    for (int c = 1; c <= 6; c++) send_request(REQ_PUSH, CODE_W'(c), 1'b0);
    send_request(REQ_PUSH, 4'd9, 1'b0);
    send_request(REQ_CONSUME, 4'd15, 1'b0);
    send_request(REQ_CONSUME, 4'd7, 1'b1);
    send_request(REQ_TICK, 4'd3, 1'b1);
    send_request(REQ_TICK, 4'd0, 1'b0);
    send_request(REQ_UNDEF_A, 4'd15, 1'b1);
    send_request(REQ_UNDEF_B, 4'd0, 1'b0);
    send_request(REQ_UNDEF_C, 4'd10, 1'b1);
    send_request(REQ_CLEAR, 4'd5, 1'b0);
    send_request(REQ_RST_COUNTS, 4'd5, 1'b1);

    // Directed: lifetime of one expires on the next tick
    drain();
    write_lifetime(8'd1);
    send_request(REQ_PUSH, 4'd10, 1'b0);
    send_request(REQ_PUSH, 4'd11, 1'b0);
    send_request(REQ_TICK, 4'd0, 1'b0);

    // Directed: lifetime of zero wraps on a tick and survives
    drain();
    write_lifetime(8'd0);
    send_request(REQ_PUSH, 4'd12, 1'b0);
    send_request(REQ_TICK, 4'd0, 1'b0);

    // Random phases, each under its own lifetime setting
    life_plan[6] = $urandom_range(1, 254);
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_lifetime(LIFE_CFG_W'(life_plan[p]));
      calm = (p % 4 == 2);
      repeat (PHASE_ITEMS) random_request();
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d push, %0d consume, %0d tick, %0d clear, %0d counter reset, %0d undefined",
             kind_seen[REQ_PUSH], kind_seen[REQ_CONSUME], kind_seen[REQ_TICK],
             kind_seen[REQ_CLEAR], kind_seen[REQ_RST_COUNTS],
             kind_seen[REQ_UNDEF_A] + kind_seen[REQ_UNDEF_B] + kind_seen[REQ_UNDEF_C]);
    $display("Checked %0d results under %0d lifetime settings", checked, settings_used);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- expiring_action_queue.f -----
+incdir+src
src/eaq_pkg.sv
src/eaq_ifs.sv
src/eaq_entry_ram.sv
src/expiring_action_queue.sv
tb/sv/eaq_status_checker.sv
tb/sv/expiring_action_queue_tb.sv
